// ----- hw/rtl/mcbc_pkg.sv -----
// shared types and constants for the multi-channel blink controller
package mcbc_pkg;

   localparam int CmdBits     = 2;
   localparam int ChannelBits = 3;
   localparam int InTimeBits  = 32;
   localparam int PinBits     = 8;

   typedef enum logic [CmdBits-1:0] {
      CMD_TICK       = 2'd0,
      CMD_SET_LEVEL  = 2'd1,
      CMD_BLINK      = 2'd2,
      CMD_SET_CONT   = 2'd3
   } cmd_type;

   // per-channel control for one transaction
   typedef struct packed {
      logic tick;
      logic set_level;
      logic blink;
      logic set_cont;
      logic level;
      logic continuous;
   } chan_ctl_type;

endpackage

// ----- hw/rtl/mcbc_channel.sv -----
// one blink timer channel: period, last update, mode and driven level
module mcbc_channel
   import mcbc_pkg::*;
#(
   parameter int TIME_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 enable,
   input  chan_ctl_type         ctl,
   input  logic [TIME_BITS-1:0] interval,
   input  logic [TIME_BITS-1:0] now,
   output logic                 level_next
);

   logic [TIME_BITS-1:0] last_update_ff, last_update_in;
   logic [TIME_BITS-1:0] period_ff, period_in;
   logic                 cont_mode_ff, cont_mode_in;
   logic                 armed_ff, armed_in;
   logic                 level_ff, level_in;
   logic [TIME_BITS-1:0] elapsed;
   logic                 expired;

   assign elapsed = now - last_update_ff;
   assign expired = elapsed > period_ff;

   always_comb begin
      last_update_in = last_update_ff;
      period_in      = period_ff;
      cont_mode_in   = cont_mode_ff;
      armed_in       = armed_ff;
      level_in       = level_ff;
      if (enable) begin
         if (ctl.tick) begin
            if (expired) begin
               last_update_in = now;
               if (cont_mode_ff) begin
                  armed_in = !armed_ff;
                  level_in = !armed_ff;
               end else begin
                  level_in = armed_ff;
                  armed_in = 1'b0;
               end
            end
         end else if (ctl.set_level) begin
            period_in = '1;
            level_in  = ctl.level;
         end else if (ctl.blink) begin
            if (period_ff != interval) begin
               last_update_in = '0;
               period_in      = interval;
            end
            cont_mode_in = ctl.continuous;
            if (!ctl.continuous) begin
               armed_in = 1'b1;
            end
         end else if (ctl.set_cont) begin
            last_update_in = '0;
            cont_mode_in   = ctl.continuous;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_update_ff <= '0;
         period_ff      <= '0;
         cont_mode_ff   <= 1'b0;
         armed_ff       <= 1'b0;
         level_ff       <= 1'b0;
      end else begin
         last_update_ff <= last_update_in;
         period_ff      <= period_in;
         cont_mode_ff   <= cont_mode_in;
         armed_ff       <= armed_in;
         level_ff       <= level_in;
      end
   end

   // level after this transaction
   assign level_next = level_in;

endmodule

// ----- hw/rtl/multi_channel_blink_controller_top.sv -----
// top level of the multi-channel blink controller
//
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_stall   command, channel, level, blink_interval,
//                                              continuous, now
//   rsp_      out        rsp_valid/rsp_stall   pin_levels
//
// one transaction per cycle unless the result side stalls
// an input register feeds all channel timers, which update in parallel
// and load the result register in the same cycle
// reset clears every channel's timer, mode and level and empties both registers
// a stalled result holds the input register, which then stalls the request side
module multi_channel_blink_controller_top
   import mcbc_pkg::*;
#(
   parameter int CHANNELS  = 8,
   parameter int TIME_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [CmdBits-1:0]     req_command,
   input  logic [ChannelBits-1:0] req_channel,
   input  logic                   req_level,
   input  logic [InTimeBits-1:0]  req_blink_interval,
   input  logic                   req_continuous,
   input  logic [InTimeBits-1:0]  req_now,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [PinBits-1:0]     rsp_pin_levels
);

   logic                   stage_valid_ff, stage_valid_in;
   cmd_type                stage_command_ff;
   logic [ChannelBits-1:0] stage_channel_ff;
   logic                   stage_level_ff;
   logic [TIME_BITS-1:0]   stage_interval_ff;
   logic                   stage_continuous_ff;
   logic [TIME_BITS-1:0]   stage_now_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [PinBits-1:0]     rsp_levels_ff, rsp_levels_in;
   logic                   advance;
   logic                   req_accept;
   logic [CHANNELS-1:0]    chan_level_next;
   logic [PinBits-1:0]     pins_next;

   assign advance    = stage_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = stage_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   assign stage_valid_in = req_accept || (stage_valid_ff && !advance);
   assign rsp_valid_in   = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         stage_command_ff    <= cmd_type'(req_command);
         stage_channel_ff    <= req_channel;
         stage_level_ff      <= req_level;
         stage_interval_ff   <= TIME_BITS'(req_blink_interval);
         stage_continuous_ff <= req_continuous;
         stage_now_ff        <= TIME_BITS'(req_now);
      end
      if (advance) begin
         rsp_levels_ff <= rsp_levels_in;
      end
   end

   genvar c;
   generate
      for (c = 0; c < CHANNELS; c++) begin : g_chan
         chan_ctl_type ctl;
         logic         hit;

         assign hit            = int'(stage_channel_ff) == c;
         assign ctl.tick       = stage_command_ff == CMD_TICK;
         assign ctl.set_level  = hit && (stage_command_ff == CMD_SET_LEVEL);
         assign ctl.blink      = hit && (stage_command_ff == CMD_BLINK);
         assign ctl.set_cont   = hit && (stage_command_ff == CMD_SET_CONT);
         assign ctl.level      = stage_level_ff;
         assign ctl.continuous = stage_continuous_ff;

         mcbc_channel #(
            .TIME_BITS (TIME_BITS)
         ) u_channel (
            .clock      (clock),
            .reset      (reset),
            .enable     (advance),
            .ctl        (ctl),
            .interval   (stage_interval_ff),
            .now        (stage_now_ff),
            .level_next (chan_level_next[c])
         );
      end

      for (c = 0; c < PinBits; c++) begin : g_pin
         if (c < CHANNELS) begin : g_used
            assign pins_next[c] = chan_level_next[c];
         end else begin : g_unused
            assign pins_next[c] = 1'b0;
         end
      end
   endgenerate

   assign rsp_levels_in  = pins_next;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pin_levels = rsp_levels_ff;

endmodule
